// ===== rtl/sidr_pkg.sv =====
// Package for the sorted ID registry: request and result word types,
// request and status codes, and the compare flags of the shared unit.
// Depends on nothing; every other file of the block imports it.
package sidr_pkg;

  localparam int ID_W  = 32;
  localparam int LEN_W = 16;
  localparam int POS_W = 6;

  // Request codes.
  localparam logic [1:0] REQ_REG   = 2'd0;
  localparam logic [1:0] REQ_FIND  = 2'd1;
  localparam logic [1:0] REQ_DEL   = 2'd2;
  localparam logic [1:0] REQ_BCAST = 2'd3;

  // Status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ERR  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // One request word.
  typedef struct packed {
    logic [1:0]       req_type;
    logic [ID_W-1:0]  user_id;
    logic [LEN_W-1:0] payload_len;
  } req_t;

  // One result word.
  typedef struct packed {
    logic [1:0]       status;
    logic [POS_W-1:0] position;
    logic             dest_valid;
    logic [ID_W-1:0]  dest_id;
    logic             last;
  } res_t;

  // Flags from the shared compare unit.
  typedef struct packed {
    logic eq;
    logic ge;
  } cmp_t;

endpackage

// ===== rtl/sidr_ram.sv =====
// Member ID store of the sorted ID registry: one write port and one
// registered read port. Depends on sidr_pkg for the ID width.
module sidr_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [sidr_pkg::ID_W-1:0] wdata,
  input  logic [AW-1:0]             raddr,
  output logic [sidr_pkg::ID_W-1:0] rdata
);
  import sidr_pkg::*;

  logic [ID_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; the data appear in the cycle after the address.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/sidr_cmp.sv =====
// Shared compare unit of the sorted ID registry: compares a stored entry
// with the request key, unsigned. Depends on sidr_pkg for cmp_t.
module sidr_cmp (
  input  logic [sidr_pkg::ID_W-1:0] entry,
  input  logic [sidr_pkg::ID_W-1:0] key,
  output sidr_pkg::cmp_t            flags
);
  import sidr_pkg::*;

  // Equality for lookup and broadcast skip, greater-or-equal for the
  // insertion point of the ascending table.
  always_comb begin
    flags.eq = (entry == key);
    flags.ge = (entry >= key);
  end

endmodule

// ===== rtl/sorted_id_registry_core.sv =====
// Top level of the sorted ID registry: request sequencer and member count.
// Depends on sidr_pkg, sidr_ram and sidr_cmp.

// The block keeps up to TABLE_DEPTH member IDs in ascending unsigned order
// and serves one request word at a time: start is taken while busy is low.
// A sequencer walks the table through one read port and one compare unit,
// reading each entry visited and then comparing it, and moves entries one
// at a time, read and then written, when an ID is inserted or deleted. A
// broadcast with a zero ID or length, or a find or delete with a zero ID,
// is rejected from the idle state without a walk of the table. Each result
// word is shown for exactly one cycle with valid high and must be taken
// then, as the receiver cannot hold results off; a broadcast emits one word
// per destination, with last set on the final one, or a single word without
// a destination if there is none. Reset clears the state, the member count
// and the held and found flags; the table contents need no clearing pass.
module sorted_id_registry_core #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  sidr_pkg::req_t req,
  output logic           busy,
  output logic           valid,
  output sidr_pkg::res_t result
);
  import sidr_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(TABLE_DEPTH);
  localparam logic [CW-1:0] ONE  = CW'(1);

  // Sequencer states.
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN_RD = 3'd1;
  localparam logic [2:0] S_SCAN_CMP= 3'd2;
  localparam logic [2:0] S_RESOLVE = 3'd3;
  localparam logic [2:0] S_SH_RD   = 3'd4;
  localparam logic [2:0] S_SH_WR   = 3'd5;
  localparam logic [2:0] S_INS     = 3'd6;

  logic [2:0]      state;
  req_t            cur;
  logic [CW-1:0]   idx;
  logic [CW-1:0]   pos;
  logic [CW-1:0]   cnt;
  logic            found;
  logic            held_v;
  logic [ID_W-1:0] held_id;

  logic [CW-1:0]   idx_inc;
  logic [CW-1:0]   idx_dec;
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [ID_W-1:0] ram_wdata;
  logic [AW-1:0]   ram_raddr;
  logic [ID_W-1:0] ram_rdata;
  cmp_t            flags;

  // Builds one result word.
  function automatic res_t mk_res(logic [1:0] st, logic [CW-1:0] p, logic dv,
                                  logic [ID_W-1:0] did, logic lst);
    res_t r;
    r.status     = st;
    r.position   = POS_W'(p);
    r.dest_valid = dv;
    r.dest_id    = did;
    r.last       = lst;
    return r;
  endfunction

  assign busy    = (state != S_IDLE);
  assign idx_inc = idx + ONE;
  assign idx_dec = idx - ONE;

  // Table store and shared compare unit.
  sidr_ram #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sidr_cmp u_cmp (
    .entry (ram_rdata),
    .key   (cur.user_id),
    .flags (flags)
  );

  // Memory port control. An insert moves entries up, reading the one below
  // the pointer; a delete moves them down, reading the one above it.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx[AW-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = idx[AW-1:0];
    case (state)
      S_SH_RD: begin
        ram_raddr = (cur.req_type == REQ_REG) ? idx_dec[AW-1:0] : idx_inc[AW-1:0];
      end
      S_SH_WR: begin
        ram_we = 1'b1;
      end
      S_INS: begin
        ram_we    = 1'b1;
        ram_waddr = pos[AW-1:0];
        ram_wdata = cur.user_id;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Request sequencer.
  always_ff @(posedge clk) begin
    valid <= 1'b0;
    if (rst) begin
      state  <= S_IDLE;
      cnt    <= '0;
      held_v <= 1'b0;
      found  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            cur    <= req;
            idx    <= '0;
            held_v <= 1'b0;
            if (req.req_type == REQ_BCAST &&
                (req.user_id == '0 || req.payload_len == '0)) begin
              valid  <= 1'b1;
              result <= mk_res(ST_ERR, '0, 1'b0, '0, 1'b1);
            end else if ((req.req_type inside {REQ_FIND, REQ_DEL}) &&
                         req.user_id == '0) begin
              valid  <= 1'b1;
              result <= mk_res(ST_ERR, '0, 1'b0, '0, 1'b1);
            end else begin
              state <= S_SCAN_RD;
            end
          end
        end

        // Issue the read of the next entry, or close the walk at the end.
        S_SCAN_RD: begin
          if (idx == cnt) begin
            if (cur.req_type == REQ_BCAST) begin
              valid <= 1'b1;
              if (held_v) begin
                result <= mk_res(ST_OK, '0, 1'b1, held_id, 1'b1);
              end else begin
                result <= mk_res(ST_OK, '0, 1'b0, '0, 1'b1);
              end
              state <= S_IDLE;
            end else begin
              found <= 1'b0;
              pos   <= idx;
              state <= S_RESOLVE;
            end
          end else begin
            state <= S_SCAN_CMP;
          end
        end

        // Compare the entry just read. A broadcast holds back one
        // destination so that the final one can be marked last.
        S_SCAN_CMP: begin
          if (cur.req_type == REQ_BCAST) begin
            if (!flags.eq) begin
              if (held_v) begin
                valid  <= 1'b1;
                result <= mk_res(ST_OK, '0, 1'b1, held_id, 1'b0);
              end
              held_v  <= 1'b1;
              held_id <= ram_rdata;
            end
            idx   <= idx_inc;
            state <= S_SCAN_RD;
          end else if (flags.ge) begin
            found <= flags.eq;
            pos   <= idx;
            state <= S_RESOLVE;
          end else begin
            idx   <= idx_inc;
            state <= S_SCAN_RD;
          end
        end

        // Act on the lookup outcome.
        S_RESOLVE: begin
          case (cur.req_type)
            REQ_REG: begin
              if (found) begin
                valid  <= 1'b1;
                result <= mk_res(ST_ERR, '0, 1'b0, '0, 1'b1);
                state  <= S_IDLE;
              end else if (cnt == FULL) begin
                valid  <= 1'b1;
                result <= mk_res(ST_FULL, '0, 1'b0, '0, 1'b1);
                state  <= S_IDLE;
              end else if (cnt > pos) begin
                idx   <= cnt;
                state <= S_SH_RD;
              end else begin
                state <= S_INS;
              end
            end
            REQ_FIND: begin
              valid <= 1'b1;
              if (found) begin
                result <= mk_res(ST_OK, pos, 1'b0, '0, 1'b1);
              end else begin
                result <= mk_res(ST_ERR, '0, 1'b0, '0, 1'b1);
              end
              state <= S_IDLE;
            end
            REQ_DEL: begin
              if (!found) begin
                valid  <= 1'b1;
                result <= mk_res(ST_ERR, '0, 1'b0, '0, 1'b1);
                state  <= S_IDLE;
              end else if ((pos + ONE) < cnt) begin
                idx   <= pos;
                state <= S_SH_RD;
              end else begin
                cnt    <= cnt - ONE;
                valid  <= 1'b1;
                result <= mk_res(ST_OK, '0, 1'b0, '0, 1'b1);
                state  <= S_IDLE;
              end
            end
            default: begin
              valid  <= 1'b1;
              result <= mk_res(ST_ERR, '0, 1'b0, '0, 1'b1);
              state  <= S_IDLE;
            end
          endcase
        end

        S_SH_RD: begin
          state <= S_SH_WR;
        end

        // The moved entry is written at the pointer by the port control.
        S_SH_WR: begin
          if (cur.req_type == REQ_REG) begin
            idx <= idx_dec;
            if (idx_dec > pos) begin
              state <= S_SH_RD;
            end else begin
              state <= S_INS;
            end
          end else begin
            idx <= idx_inc;
            if ((idx_inc + ONE) < cnt) begin
              state <= S_SH_RD;
            end else begin
              cnt    <= cnt - ONE;
              valid  <= 1'b1;
              result <= mk_res(ST_OK, '0, 1'b0, '0, 1'b1);
              state  <= S_IDLE;
            end
          end
        end

        // The new ID is written into the gap by the port control.
        S_INS: begin
          cnt    <= cnt + ONE;
          valid  <= 1'b1;
          result <= mk_res(ST_OK, pos, 1'b0, '0, 1'b1);
          state  <= S_IDLE;
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/sidr_checker.sv =====
// Port checker for the sorted ID registry and the bind that attaches it
// to sorted_id_registry_core. Depends on sidr_pkg.
module sidr_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input sidr_pkg::req_t req,
  input logic           busy,
  input logic           valid,
  input sidr_pkg::res_t result
);
  import sidr_pkg::*;

  // An accepted request either keeps the block busy or answers at once.
  a_accept_answers: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || valid))
    else $error("accepted request neither busy nor answered");

  // A word that is not the last of its request leaves the block busy.
  a_more_follows: assert property (@(posedge clk) disable iff (rst)
    (valid && !result.last) |-> busy)
    else $error("non-final result word while idle");

  // Only broadcast destinations are words without last.
  a_nonlast_is_dest: assert property (@(posedge clk) disable iff (rst)
    (valid && !result.last) |-> result.dest_valid)
    else $error("non-final result word without a destination");

  // A destination word carries status ok and position zero.
  a_dest_fields: assert property (@(posedge clk) disable iff (rst)
    (valid && result.dest_valid) |-> (result.status == ST_OK && result.position == '0))
    else $error("destination word with bad status or position");

endmodule

bind sorted_id_registry_core sidr_checker u_sidr_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .req    (req),
  .busy   (busy),
  .valid  (valid),
  .result (result)
);
